>>> src/online_mean_covariance_assert.svh
// Assertion macros for the online mean and covariance block.
// Each check is sampled on the rising edge of clk and ignored while rst_n is low.
`ifndef ONLINE_MEAN_COVARIANCE_ASSERT_SVH
`define ONLINE_MEAN_COVARIANCE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define OMC_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("online_mean_covariance: same-cycle check failed");
// Next-cycle implication
`define OMC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("online_mean_covariance: next-cycle check failed");
`else
`define OMC_ASSERT_IMP(label, pre, post)
`define OMC_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> src/omc_pkg.sv
`timescale 1ns / 1ps

package omc_pkg;

    localparam int CHANNELS      = 8;
    localparam int SAMPLE_INPUTS = 8;
    localparam int ACT_LIM       = (CHANNELS < SAMPLE_INPUTS) ? CHANNELS : SAMPLE_INPUTS;
    localparam int CH_W          = $clog2(CHANNELS);
    localparam int CNT_W         = $clog2(ACT_LIM + 1);
    localparam int SMP_W         = $clog2(SAMPLE_INPUTS);
    localparam int TRI_SIZE      = CHANNELS * (CHANNELS + 1) / 2;
    localparam int TRI_W         = $clog2(TRI_SIZE);

    localparam int MEAN_W = 48;
    localparam int DEL_W  = 49;
    localparam int CM_W   = 64;
    localparam int PROD_W = 96;
    localparam int HALF_W = 24;
    localparam int INC_W  = 80;
    localparam int DCNT_W = 7;

    // Item kinds
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_ACCUM     = 3'd0;
    localparam logic [2:0] ST_READ_OK   = 3'd1;
    localparam logic [2:0] ST_BAD_INDEX = 3'd2;
    localparam logic [2:0] ST_NO_EVENTS = 3'd3;
    localparam logic [2:0] ST_ONE_EVENT = 3'd4;

    typedef struct packed {
        logic               action;
        logic signed [31:0] sample_0;
        logic signed [31:0] sample_1;
        logic signed [31:0] sample_2;
        logic signed [31:0] sample_3;
        logic signed [31:0] sample_4;
        logic signed [31:0] sample_5;
        logic signed [31:0] sample_6;
        logic signed [31:0] sample_7;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        event_count;
        logic signed [47:0] mean_row;
        logic signed [47:0] mean_col;
        logic signed [63:0] co_moment;
        logic               saturated;
    } out_word_t;

    // Clamp the channel register to the usable range
    function automatic logic [CNT_W-1:0] active_count(input logic [3:0] cfg);
        logic [CNT_W-1:0] res;
        if (cfg == 4'd0)
            res = CNT_W'(1);
        else if (int'(cfg) > ACT_LIM)
            res = CNT_W'(ACT_LIM);
        else
            res = CNT_W'(cfg);
        return res;
    endfunction

    // Address of the upper-triangle entry (r, c), r <= c
    function automatic logic [TRI_W-1:0] tri_index(input logic [CH_W-1:0] r,
                                                  input logic [CH_W-1:0] c);
        int ri;
        int ci;
        int t;
        ri = int'(r);
        ci = int'(c);
        t  = (ri * (2 * CHANNELS - ri + 1)) >> 1;
        return TRI_W'(t + ci - ri);
    endfunction

    // Add a signed increment to a co-moment; top bit is the saturation flag
    function automatic logic [CM_W:0] sat_accumulate(input logic [CM_W-1:0] acc,
                                                     input logic neg,
                                                     input logic [INC_W-1:0] inc);
        logic [CM_W:0]   sum;
        logic [CM_W-1:0] mag;
        logic [CM_W-1:0] ext;
        logic [CM_W:0]   res;
        ext = neg ? {1'b1, {(CM_W-1){1'b0}}} : {1'b0, {(CM_W-1){1'b1}}};
        mag = inc[CM_W-1:0];
        if (inc[INC_W-1:CM_W-1] != '0)
        begin
            res = {1'b1, ext};
        end
        else
        begin
            if (neg)
                sum = {acc[CM_W-1], acc} - {1'b0, mag};
            else
                sum = {acc[CM_W-1], acc} + {1'b0, mag};
            if (sum[CM_W] != sum[CM_W-1])
                res = {1'b1, ext};
            else
                res = {1'b0, sum[CM_W-1:0]};
        end
        return res;
    endfunction

endpackage

>>> src/omc_ram.sv
`timescale 1ns / 1ps

module omc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> src/online_mean_covariance.sv
`timescale 1ns / 1ps
// Read word: result valid after states S_R_1, S_R_2 and S_R_3 (directly from idle for a bad index or no events).
// Accumulate, first event: set the means and clear the active triangle; later events: update each
// mean and diagonal, then each off-diagonal pair, on the shared serial divider and 24x24 multiplier.
// One word at a time; the next is taken the cycle after the result word has been taken.
// Reset (rst_n low, asynchronous) clears count, saturation flag and control, sets channels to 8;
// the mean and co-moment RAMs are not cleared.
`include "online_mean_covariance_assert.svh"

module online_mean_covariance import omc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data,
    input  logic      cfg_wen,
    input  logic [3:0] cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_FIRST, S_A_RD, S_A_DEL, S_A_DIV, S_A_MUL, S_A_ADD,
        S_B_RI, S_B_RJ, S_B_CAP, S_B_MUL, S_B_LD, S_B_DIV, S_B_ADD,
        S_R_1, S_R_2, S_R_3, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [3:0]              cfg_reg;
    logic [31:0]             count_reg;
    logic                    sat_reg;
    logic                    out_valid_reg;
    out_word_t               out_reg;
    in_word_t                item_reg;
    logic [CNT_W-1:0]        i_reg;
    logic [CNT_W-1:0]        j_reg;
    logic [MEAN_W-1:0]       mean_old_reg;
    logic [DEL_W-1:0]        del_reg;
    logic [DEL_W-1:0]        di_reg;
    logic [MEAN_W-1:0]       mean_row_reg;
    logic [31:0]             div_rem_reg;
    logic [PROD_W-1:0]       div_q_reg;
    logic [DCNT_W-1:0]       div_cnt_reg;
    logic [MEAN_W-1:0]       mul_a_reg;
    logic [MEAN_W-1:0]       mul_b_reg;
    logic                    mul_neg_reg;
    logic [2:0]              mul_k_reg;
    logic [2*HALF_W-1:0]     pp_reg;
    logic [1:0]              pp_sh_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic [CNT_W-1:0]        act_c;
    logic signed [31:0]      smp [SAMPLE_INPUTS];
    logic [MEAN_W-1:0]       u_c;
    logic [DEL_W-1:0]        del_c;
    logic [MEAN_W-1:0]       quot_s_c;
    logic [MEAN_W-1:0]       newmean_c;
    logic [DEL_W-1:0]        a_c;
    logic [32:0]             trial_c;
    logic                    ge_c;
    logic [HALF_W-1:0]       ah_c;
    logic [HALF_W-1:0]       bh_c;
    logic [2*HALF_W-1:0]     pp_c;
    logic [PROD_W-1:0]       pp_shift_c;
    logic [PROD_W-1:0]       res_c;
    logic [INC_W-1:0]        inc_c;
    logic [CM_W:0]           sat_c;
    logic [3:0]              in_hi_c;
    logic [3:0]              it_hi_c;
    logic [3:0]              it_lo_c;
    logic [31:0]             count_inc_c;

    logic                    mean_we;
    logic [CH_W-1:0]         mean_waddr;
    logic [MEAN_W-1:0]       mean_wdata;
    logic [CH_W-1:0]         mean_raddr;
    logic [MEAN_W-1:0]       mean_rdata;
    logic                    del_we;
    logic [CH_W-1:0]         del_raddr;
    logic [DEL_W-1:0]        del_rdata;
    logic                    co_we;
    logic [TRI_W-1:0]        co_waddr;
    logic [CM_W-1:0]         co_wdata;
    logic [TRI_W-1:0]        co_raddr;
    logic [CM_W-1:0]         co_rdata;

    function automatic logic [MEAN_W-1:0] mag48(input logic [DEL_W-1:0] v);
        logic [DEL_W-1:0] t;
        t = v[DEL_W-1] ? (~v + 1'b1) : v;
        return t[MEAN_W-1:0];
    endfunction

    // Sample selection and arithmetic
    always_comb
    begin
        smp[0] = item_reg.sample_0;
        smp[1] = item_reg.sample_1;
        smp[2] = item_reg.sample_2;
        smp[3] = item_reg.sample_3;
        smp[4] = item_reg.sample_4;
        smp[5] = item_reg.sample_5;
        smp[6] = item_reg.sample_6;
        smp[7] = item_reg.sample_7;
    end

    assign act_c       = active_count(cfg_reg);
    assign u_c         = {smp[SMP_W'(i_reg)], 16'h0000};
    assign del_c       = {u_c[MEAN_W-1], u_c} - {mean_rdata[MEAN_W-1], mean_rdata};
    assign quot_s_c    = del_reg[DEL_W-1] ? (~div_q_reg[MEAN_W-1:0] + 1'b1)
                                          : div_q_reg[MEAN_W-1:0];
    assign newmean_c   = mean_old_reg + quot_s_c;
    assign a_c         = {u_c[MEAN_W-1], u_c} - {newmean_c[MEAN_W-1], newmean_c};
    assign count_inc_c = (count_reg == '1) ? count_reg : count_reg + 32'd1;

    // Divider step: one quotient bit
    assign trial_c = {div_rem_reg, div_q_reg[PROD_W-1]};
    assign ge_c    = trial_c >= {1'b0, count_reg};

    // Multiplier: one 24x24 partial product per cycle
    assign ah_c = mul_k_reg[1] ? mul_a_reg[2*HALF_W-1:HALF_W] : mul_a_reg[HALF_W-1:0];
    assign bh_c = mul_k_reg[0] ? mul_b_reg[2*HALF_W-1:HALF_W] : mul_b_reg[HALF_W-1:0];
    assign pp_c = ah_c * bh_c;

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_shift_c = PROD_W'(pp_reg);
            2'd1:    pp_shift_c = PROD_W'(pp_reg) << HALF_W;
            default: pp_shift_c = PROD_W'(pp_reg) << (2 * HALF_W);
        endcase
    end

    // Off-diagonal: P*(n-1)/n = P - ceil(P/n)
    assign res_c = prod_reg - div_q_reg - PROD_W'(div_rem_reg != 32'd0);
    assign inc_c = (state_reg == S_B_ADD) ? res_c[PROD_W-1:16] : prod_reg[PROD_W-1:16];
    assign sat_c = sat_accumulate(co_rdata, mul_neg_reg, inc_c);

    assign in_hi_c = (in_data.row_index > in_data.col_index) ? in_data.row_index
                                                             : in_data.col_index;
    assign it_hi_c = (item_reg.row_index > item_reg.col_index) ? item_reg.row_index
                                                               : item_reg.col_index;
    assign it_lo_c = (item_reg.row_index > item_reg.col_index) ? item_reg.col_index
                                                               : item_reg.row_index;

    // Memory port steering
    always_comb
    begin
        mean_we    = 1'b0;
        mean_waddr = CH_W'(i_reg);
        mean_wdata = u_c;
        mean_raddr = CH_W'(i_reg);
        del_we     = 1'b0;
        del_raddr  = CH_W'(i_reg);
        co_we      = 1'b0;
        co_waddr   = tri_index(CH_W'(i_reg), CH_W'(j_reg));
        co_wdata   = sat_c[CM_W-1:0];
        co_raddr   = tri_index(CH_W'(i_reg), CH_W'(j_reg));
        case (state_reg)
            S_FIRST:
            begin
                co_we    = 1'b1;
                co_wdata = '0;
                mean_we  = (i_reg == j_reg);
            end
            S_A_DEL:
            begin
                del_we = 1'b1;
            end
            S_A_DIV:
            begin
                mean_we    = (div_cnt_reg == '0);
                mean_wdata = newmean_c;
            end
            S_A_ADD, S_B_ADD:
            begin
                co_we = 1'b1;
            end
            S_B_RJ:
            begin
                del_raddr = CH_W'(j_reg);
            end
            S_R_1:
            begin
                mean_raddr = CH_W'(item_reg.row_index);
                co_raddr   = tri_index(CH_W'(it_lo_c), CH_W'(it_hi_c));
            end
            S_R_2:
            begin
                mean_raddr = CH_W'(item_reg.col_index);
                co_raddr   = tri_index(CH_W'(it_lo_c), CH_W'(it_hi_c));
            end
            default:
            begin
                mean_we = 1'b0;
            end
        endcase
    end

    omc_ram #(.WIDTH(MEAN_W), .DEPTH(CHANNELS)) u_mean_ram (
        .clk   (clk),
        .we    (mean_we),
        .waddr (mean_waddr),
        .wdata (mean_wdata),
        .raddr (mean_raddr),
        .rdata (mean_rdata)
    );

    omc_ram #(.WIDTH(DEL_W), .DEPTH(CHANNELS)) u_del_ram (
        .clk   (clk),
        .we    (del_we),
        .waddr (CH_W'(i_reg)),
        .wdata (del_c),
        .raddr (del_raddr),
        .rdata (del_rdata)
    );

    omc_ram #(.WIDTH(CM_W), .DEPTH(TRI_SIZE)) u_co_ram (
        .clk   (clk),
        .we    (co_we),
        .waddr (co_waddr),
        .wdata (co_wdata),
        .raddr (co_raddr),
        .rdata (co_rdata)
    );

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= 4'd8;
            count_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            item_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            mean_old_reg  <= '0;
            del_reg       <= '0;
            di_reg        <= '0;
            mean_row_reg  <= '0;
            div_rem_reg   <= '0;
            div_q_reg     <= '0;
            div_cnt_reg   <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_neg_reg   <= 1'b0;
            mul_k_reg     <= '0;
            pp_reg        <= '0;
            pp_sh_reg     <= '0;
            prod_reg      <= '0;
        end
        else
        begin
            if (cfg_wen)
                cfg_reg <= cfg_wdata;

            // Drop the result word once taken
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // Shared divider step
            if ((state_reg == S_A_DIV || state_reg == S_B_DIV) && div_cnt_reg != '0)
            begin
                div_rem_reg <= ge_c ? 32'(trial_c - {1'b0, count_reg}) : trial_c[31:0];
                div_q_reg   <= {div_q_reg[PROD_W-2:0], ge_c};
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end

            // Shared multiplier step
            if (state_reg == S_A_MUL || state_reg == S_B_MUL)
            begin
                if (mul_k_reg != 3'd4)
                begin
                    pp_reg    <= pp_c;
                    pp_sh_reg <= {1'b0, mul_k_reg[1]} + {1'b0, mul_k_reg[0]};
                end
                if (mul_k_reg != 3'd0)
                    prod_reg <= prod_reg + pp_shift_c;
                mul_k_reg <= mul_k_reg + 3'd1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        item_reg <= in_data;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        if (in_data.action == ACT_ACCUM)
                        begin
                            count_reg <= count_inc_c;
                            state_reg <= (count_inc_c == 32'd1) ? S_FIRST : S_A_RD;
                        end
                        else if (8'(in_hi_c) >= 8'(act_c))
                        begin
                            out_reg       <= '{ST_BAD_INDEX, count_reg, '0, '0, '0, sat_reg};
                            out_valid_reg <= 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            out_reg       <= '{ST_NO_EVENTS, count_reg, '0, '0, '0, sat_reg};
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_R_1;
                        end
                    end
                end

                // First event: set means, clear the active triangle
                S_FIRST:
                begin
                    if (j_reg == act_c - 1'b1)
                    begin
                        if (i_reg == act_c - 1'b1)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end

                S_A_RD:
                begin
                    state_reg <= S_A_DEL;
                end

                // Form delta against the old mean, start delta/n
                S_A_DEL:
                begin
                    mean_old_reg <= mean_rdata;
                    del_reg      <= del_c;
                    div_rem_reg  <= '0;
                    div_q_reg    <= {mag48(del_c), {(PROD_W-MEAN_W){1'b0}}};
                    div_cnt_reg  <= DCNT_W'(MEAN_W);
                    state_reg    <= S_A_DIV;
                end

                // New mean written here; start the diagonal product
                S_A_DIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        mul_a_reg   <= mag48(a_c);
                        mul_b_reg   <= mag48(del_reg);
                        mul_neg_reg <= a_c[DEL_W-1] ^ del_reg[DEL_W-1];
                        mul_k_reg   <= '0;
                        prod_reg    <= '0;
                        state_reg   <= S_A_MUL;
                    end
                end

                S_A_MUL:
                begin
                    if (mul_k_reg == 3'd4)
                        state_reg <= S_A_ADD;
                end

                S_A_ADD:
                begin
                    sat_reg <= sat_reg | sat_c[CM_W];
                    if (i_reg == act_c - 1'b1)
                    begin
                        if (act_c == CNT_W'(1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg     <= '0;
                            j_reg     <= CNT_W'(1);
                            state_reg <= S_B_RI;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= i_reg + 1'b1;
                        state_reg <= S_A_RD;
                    end
                end

                S_B_RI:
                begin
                    state_reg <= S_B_RJ;
                end

                S_B_RJ:
                begin
                    di_reg    <= del_rdata;
                    state_reg <= S_B_CAP;
                end

                S_B_CAP:
                begin
                    mul_a_reg   <= mag48(di_reg);
                    mul_b_reg   <= mag48(del_rdata);
                    mul_neg_reg <= di_reg[DEL_W-1] ^ del_rdata[DEL_W-1];
                    mul_k_reg   <= '0;
                    prod_reg    <= '0;
                    state_reg   <= S_B_MUL;
                end

                S_B_MUL:
                begin
                    if (mul_k_reg == 3'd4)
                        state_reg <= S_B_LD;
                end

                S_B_LD:
                begin
                    div_rem_reg <= '0;
                    div_q_reg   <= prod_reg;
                    div_cnt_reg <= DCNT_W'(PROD_W);
                    state_reg   <= S_B_DIV;
                end

                S_B_DIV:
                begin
                    if (div_cnt_reg == '0)
                        state_reg <= S_B_ADD;
                end

                S_B_ADD:
                begin
                    sat_reg <= sat_reg | sat_c[CM_W];
                    if (j_reg == act_c - 1'b1)
                    begin
                        if (i_reg == act_c - CNT_W'(2))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            j_reg     <= i_reg + CNT_W'(2);
                            state_reg <= S_B_RI;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_B_RI;
                    end
                end

                S_R_1:
                begin
                    state_reg <= S_R_2;
                end

                S_R_2:
                begin
                    mean_row_reg <= mean_rdata;
                    state_reg    <= S_R_3;
                end

                S_R_3:
                begin
                    out_reg.event_count <= count_reg;
                    out_reg.mean_row    <= mean_row_reg;
                    out_reg.mean_col    <= mean_rdata;
                    out_reg.saturated   <= sat_reg;
                    if (count_reg < 32'd2)
                    begin
                        out_reg.status    <= ST_ONE_EVENT;
                        out_reg.co_moment <= '0;
                    end
                    else
                    begin
                        out_reg.status    <= ST_READ_OK;
                        out_reg.co_moment <= co_rdata;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end

                S_DONE:
                begin
                    out_reg       <= '{ST_ACCUM, count_reg, '0, '0, '0, sat_reg};
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    `OMC_ASSERT_IMP(a_busy_out_empty, (state_reg != S_IDLE), !out_valid_reg)
    `OMC_ASSERT_NEXT(a_sat_sticky, sat_reg, sat_reg)
    `OMC_ASSERT_NEXT(a_count_held, (state_reg != S_IDLE), $stable(count_reg))
    `OMC_ASSERT_IMP(a_div_state, (div_cnt_reg != '0), (state_reg == S_A_DIV || state_reg == S_B_DIV))

endmodule
